[rtl/bfsc_pkg.sv]
// ----------------------------------------------------------------------------
// Frame sync checker package
// Types and constants for the binary frame sync checker.
// ----------------------------------------------------------------------------
package bfsc_pkg;

  localparam logic [7:0]  SYNC_A         = 8'hA0;
  localparam logic [7:0]  SYNC_B         = 8'hA1;
  localparam logic [7:0]  TRAIL_CR       = 8'h0D;
  localparam logic [7:0]  TRAIL_LF       = 8'h0A;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
  localparam logic [16:0] MAX_LEN_RESET  = 17'd4096;

  localparam logic [16:0] POS_HUNT = 17'd0;
  localparam logic [16:0] POS_LENH = 17'd2;
  localparam logic [16:0] POS_LENL = 17'd3;
  localparam logic [16:0] POS_BODY = 17'd4;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_OK        = 3'd1,
    KIND_SUM_ERR   = 3'd2,
    KIND_TRAIL_ERR = 3'd3,
    KIND_LEN_ERR   = 3'd4
  } kind_t;

endpackage

[rtl/binary_frame_sync_checker.sv]
// ----------------------------------------------------------------------------
// Binary frame sync checker
// Hunts for the sync pair, reads the frame length, forwards payload bytes
// with their index and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte), one
// byte per beat. Results leave on the res channel (res_valid, res_stall and
// the result fields), at most one beat per received byte. A beat is taken at
// a rising edge where valid is high and stall is low.
// An accepted byte is held in an input register while the frame state is
// updated, and its result is written into the result register as it leaves.
// One byte per cycle is sustained while the receiver does not stall.
// The frame length limit is written through cfg_we and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset clears the frame state to hunting, empties both registers and sets
// the limit to 4096 bytes. While the receiver stalls a waiting result, one
// more byte is taken into the input register, then rx_stall is raised.
// ----------------------------------------------------------------------------
module binary_frame_sync_checker
  import bfsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  message_id,
  output logic [15:0] payload_len
);

  logic [16:0] max_frame_len;

  logic        in_valid;
  logic [7:0]  in_byte;

  logic [7:0]  hunt_prev, hunt_prev_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  len_high, len_high_next;
  logic [16:0] frame_len, frame_len_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  first_payload, first_payload_next;
  logic        sum_match, sum_match_next;
  logic        cr_match, cr_match_next;

  kind_t       res_kind, res_kind_next;
  logic [7:0]  res_byte, res_byte_next;
  logic [15:0] res_index, res_index_next;
  logic [7:0]  res_id, res_id_next;
  logic [15:0] res_len, res_len_next;
  logic        emit;

  logic        advance;
  logic [15:0] hdr;
  logic [15:0] plen;
  logic [16:0] body_end;
  logic [16:0] idx;
  logic [7:0]  first_now;

  assign advance  = in_valid && (!res_valid || !res_stall);
  assign rx_stall = in_valid && !advance;

  assign hdr      = {len_high, in_byte};
  assign plen     = frame_len[15:0] - FRAME_OVERHEAD[15:0];
  assign body_end = frame_len - 17'd3;
  assign idx      = byte_count - POS_BODY;

  always_comb begin
    hunt_prev_next     = hunt_prev;
    byte_count_next    = byte_count;
    len_high_next      = len_high;
    frame_len_next     = frame_len;
    running_xor_next   = running_xor;
    first_payload_next = first_payload;
    sum_match_next     = sum_match;
    cr_match_next      = cr_match;
    emit               = 1'b0;
    res_kind_next      = KIND_PAYLOAD;
    res_byte_next      = 8'd0;
    res_index_next     = 16'd0;
    res_id_next        = 8'd0;
    res_len_next       = 16'd0;
    first_now          = first_payload;

    priority if (byte_count == POS_HUNT) begin
      hunt_prev_next = in_byte;
      if (hunt_prev == SYNC_A && in_byte == SYNC_B) begin
        byte_count_next    = POS_LENH;
        running_xor_next   = 8'd0;
        first_payload_next = 8'd0;
        sum_match_next     = 1'b0;
        cr_match_next      = 1'b0;
      end
    end else if (byte_count == POS_LENH) begin
      len_high_next   = in_byte;
      byte_count_next = POS_LENL;
    end else if (byte_count == POS_LENL) begin
      frame_len_next = {1'b0, hdr} + FRAME_OVERHEAD;
      if (frame_len_next > max_frame_len) begin
        byte_count_next = POS_HUNT;
        emit            = 1'b1;
        res_kind_next   = KIND_LEN_ERR;
        res_len_next    = hdr;
      end else begin
        byte_count_next = POS_BODY;
      end
    end else if (byte_count < body_end) begin
      byte_count_next = byte_count + 17'd1;
      if (idx == 17'd0) begin
        first_now = in_byte;
      end
      first_payload_next = first_now;
      running_xor_next   = running_xor ^ in_byte;
      emit               = 1'b1;
      res_kind_next      = KIND_PAYLOAD;
      res_byte_next      = in_byte;
      res_index_next     = idx[15:0];
      res_id_next        = first_now;
      res_len_next       = plen;
    end else if (byte_count == body_end) begin
      byte_count_next = byte_count + 17'd1;
      sum_match_next  = (in_byte == running_xor);
    end else if (byte_count == body_end + 17'd1) begin
      byte_count_next = byte_count + 17'd1;
      cr_match_next   = (in_byte == TRAIL_CR);
    end else begin
      byte_count_next = POS_HUNT;
      emit            = 1'b1;
      if (!sum_match) begin
        res_kind_next = KIND_SUM_ERR;
      end else if (!cr_match || in_byte != TRAIL_LF) begin
        res_kind_next = KIND_TRAIL_ERR;
      end else begin
        res_kind_next = KIND_OK;
      end
      res_id_next  = first_payload;
      res_len_next = plen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_frame_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_prev     <= 8'd0;
      byte_count    <= POS_HUNT;
      len_high      <= 8'd0;
      frame_len     <= 17'd0;
      running_xor   <= 8'd0;
      first_payload <= 8'd0;
      sum_match     <= 1'b0;
      cr_match      <= 1'b0;
    end else if (advance) begin
      hunt_prev     <= hunt_prev_next;
      byte_count    <= byte_count_next;
      len_high      <= len_high_next;
      frame_len     <= frame_len_next;
      running_xor   <= running_xor_next;
      first_payload <= first_payload_next;
      sum_match     <= sum_match_next;
      cr_match      <= cr_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_kind  <= res_kind_next;
      res_byte  <= res_byte_next;
      res_index <= res_index_next;
      res_id    <= res_id_next;
      res_len   <= res_len_next;
    end
  end

  assign kind          = res_kind;
  assign payload_byte  = res_byte;
  assign payload_index = res_index;
  assign message_id    = res_id;
  assign payload_len   = res_len;

endmodule

[bench/tb_binary_frame_sync_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame sync checker testbench
// Sends a short table of directed bytes and then random frames, noise and
// broken frames through the checker. The frame length limit is changed
// between phases. Every result beat is compared field by field with a
// predicted one. Both channels idle at random, and the receiver sometimes
// holds off for a long time.
// ----------------------------------------------------------------------------
module tb_binary_frame_sync_checker;
  import bfsc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [7:0]  mid;
    logic [15:0] plen;
  } frame_res_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    frame_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_data = 17'd0;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  message_id;
  logic [15:0] payload_len;

  // Predicted frame state.
  logic [16:0] fs_limit = MAX_LEN_RESET;
  logic [7:0]  fs_prev = 8'h00;
  logic [16:0] fs_pos = POS_HUNT;
  logic [7:0]  fs_len_hi = 8'h00;
  logic [16:0] fs_frame_len = 17'd0;
  logic [7:0]  fs_xor = 8'h00;
  logic [7:0]  fs_first = 8'h00;
  bit          fs_sum_ok = 1'b0;
  bit          fs_cr_ok = 1'b0;

  frame_res_t pending_res[$];
  dir_row_t   dir_rows[$];
  int         errors = 0;
  int         cycles = 0;
  int         bytes_sent = 0;
  bit         rx_held = 1'b0;
  bit         tx_no_gaps = 1'b0;
  bit         rx_no_stall = 1'b0;
  bit         long_hold_req = 1'b0;
  int         rcv_left = 0;
  int         rcv_pick;
  frame_res_t want;

  binary_frame_sync_checker i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .message_id   (message_id),
    .payload_len  (payload_len)
  );

  always #4 clk = ~clk;

  task automatic frame_step(input logic [7:0] b, output bit got, output frame_res_t r);
    logic [16:0] pos;
    logic [16:0] plen17;
    logic [15:0] hdr;
    pos = fs_pos;
    plen17 = fs_frame_len - FRAME_OVERHEAD;
    got = 1'b0;
    r = '0;
    if (pos == POS_HUNT) begin
      if (fs_prev == SYNC_A && b == SYNC_B) begin
        fs_pos = POS_LENH;
        fs_xor = 8'h00;
        fs_first = 8'h00;
        fs_sum_ok = 1'b0;
        fs_cr_ok = 1'b0;
      end
      fs_prev = b;
    end else if (pos == POS_LENH) begin
      fs_len_hi = b;
      fs_pos = POS_LENL;
    end else if (pos == POS_LENL) begin
      hdr = {fs_len_hi, b};
      fs_frame_len = {1'b0, hdr} + FRAME_OVERHEAD;
      if (fs_frame_len > fs_limit) begin
        fs_pos = POS_HUNT;
        got = 1'b1;
        r.kind = KIND_LEN_ERR;
        r.plen = hdr;
      end else begin
        fs_pos = POS_BODY;
      end
    end else begin
      fs_pos = pos + 17'd1;
      if (pos < fs_frame_len - 17'd3) begin
        if (pos == POS_BODY) fs_first = b;
        fs_xor = fs_xor ^ b;
        got = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.pbyte = b;
        r.pidx = pos[15:0] - POS_BODY[15:0];
        r.mid = fs_first;
        r.plen = plen17[15:0];
      end else if (pos == fs_frame_len - 17'd3) begin
        fs_sum_ok = (b == fs_xor);
      end else if (pos == fs_frame_len - 17'd2) begin
        fs_cr_ok = (b == TRAIL_CR);
      end else begin
        fs_pos = POS_HUNT;
        got = 1'b1;
        r.mid = fs_first;
        r.plen = plen17[15:0];
        if (!fs_sum_ok) r.kind = KIND_SUM_ERR;
        else if (!fs_cr_ok || b != TRAIL_LF) r.kind = KIND_TRAIL_ERR;
        else r.kind = KIND_OK;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t fixed);
    bit         got;
    frame_res_t r;
    int         gap;
    int         pick;
    rx_byte <= b;
    if (!rx_held) begin
      rx_valid <= 1'b1;
      rx_held = 1'b1;
    end
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
    frame_step(b, got, r);
    if (typed) begin
      got = 1'b1;
      r = fixed;
    end
    if (got) pending_res.push_back(r);
    if (tx_no_gaps) begin
      gap = 0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) gap = 0;
      else if (pick < 93) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      rx_valid <= 1'b0;
      rx_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic wait_drained();
    if (rx_held) begin
      rx_valid <= 1'b0;
      rx_held = 1'b0;
    end
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fs_limit = v;
  endtask

  task automatic row(input logic [7:0] b);
    dir_row_t d;
    d.b = b;
    d.typed = 1'b0;
    d.res = '0;
    dir_rows.push_back(d);
  endtask

  task automatic row_exp(input logic [7:0] b, input kind_t k, input logic [7:0] pb,
                         input logic [15:0] pi, input logic [7:0] mid,
                         input logic [15:0] pl);
    dir_row_t d;
    d.b = b;
    d.typed = 1'b1;
    d.res.kind = k;
    d.res.pbyte = pb;
    d.res.pidx = pi;
    d.res.mid = mid;
    d.res.plen = pl;
    dir_rows.push_back(d);
  endtask

  task automatic send_frame(input logic [16:0] lim);
    int         sel;
    int         li;
    logic [15:0] hdr;
    logic [7:0] x;
    logic [7:0] pb;
    li = int'(lim);
    if ($urandom_range(3) == 0) repeat ($urandom_range(4, 1)) put_byte(8'($urandom_range(255)));
    sel = $urandom_range(99);
    if (sel < 6) begin
      put_byte(SYNC_A);
      put_byte(8'($urandom_range(255)));
      return;
    end
    if (sel < 70) hdr = 16'($urandom_range(12));
    else if (sel < 80) hdr = 16'($urandom_range(60, 13));
    else if (sel < 90 && li >= 7 && li <= 400) hdr = 16'(li - 7 + $urandom_range(1));
    else if (sel >= 90 && li <= 65541) hdr = 16'($urandom_range(65535, (li < 7) ? 0 : li - 6));
    else hdr = 16'($urandom_range(12));
    put_byte(SYNC_A);
    put_byte(SYNC_B);
    put_byte(hdr[15:8]);
    put_byte(hdr[7:0]);
    if (hdr + 7 > li) return;
    x = 8'h00;
    for (int i = 0; i < hdr; i++) begin
      if ($urandom_range(199) == 0) return;
      pb = 8'($urandom_range(255));
      x = x ^ pb;
      put_byte(pb);
    end
    put_byte(($urandom_range(99) < 85) ? x : x ^ 8'($urandom_range(255, 1)));
    put_byte(($urandom_range(9) != 0) ? TRAIL_CR : 8'($urandom_range(255)));
    put_byte(($urandom_range(9) != 0) ? TRAIL_LF : 8'($urandom_range(255)));
  endtask

  task automatic run_phase(input logic [16:0] lim, input int nbytes, input bit hold_off,
                           input bit pause_mid);
    int  start;
    bit  paused;
    wait_drained();
    repeat (6) @(posedge clk);
    write_limit(lim);
    tx_no_gaps = ($urandom_range(3) == 0);
    rx_no_stall = ($urandom_range(3) == 0);
    if (hold_off) long_hold_req = 1'b1;
    paused = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      if (pause_mid && !paused && bytes_sent - start >= nbytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_frame(lim);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (pending_res.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", kind);
          errors++;
        end else begin
          want = pending_res.pop_front();
          check_field("kind", {13'd0, want.kind}, {13'd0, kind});
          check_field("payload_byte", {8'd0, want.pbyte}, {8'd0, payload_byte});
          check_field("payload_index", want.pidx, payload_index);
          check_field("message_id", {8'd0, want.mid}, {8'd0, message_id});
          check_field("payload_len", want.plen, payload_len);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_stall <= 1'b1;
        rcv_left = 400;
      end else if (rcv_left > 0) begin
        rcv_left--;
      end else if (rx_no_stall) begin
        res_stall <= 1'b0;
      end else begin
        rcv_pick = $urandom_range(99);
        if (rcv_pick < 60) begin
          res_stall <= 1'b0;
          rcv_left = $urandom_range(6);
        end else if (rcv_pick < 94) begin
          res_stall <= 1'b1;
          rcv_left = $urandom_range(2);
        end else begin
          res_stall <= 1'b1;
          rcv_left = $urandom_range(60, 15);
        end
      end
    end
  end

  initial begin
    // Smallest frame, empty payload.
    row(SYNC_A); row(SYNC_B); row(8'h00); row(8'h00); row(8'h00); row(TRAIL_CR);
    row_exp(TRAIL_LF, KIND_OK, 8'h00, 16'd0, 8'h00, 16'd0);
    // The hunt still remembers the last sync byte, so a lone second sync byte does nothing.
    row(SYNC_B);
    row(SYNC_A); row(SYNC_B); row(8'hFF);
    row_exp(8'hFF, KIND_LEN_ERR, 8'h00, 16'd0, 8'h00, 16'hFFFF);
    // Both checksum and trailer wrong.
    row(SYNC_A); row(SYNC_B); row(8'h00); row(8'h01);
    row_exp(8'hFF, KIND_PAYLOAD, 8'hFF, 16'd0, 8'hFF, 16'd1);
    row(8'h00); row(8'h00);
    row_exp(TRAIL_LF, KIND_SUM_ERR, 8'h00, 16'd0, 8'hFF, 16'd1);
    // Good checksum, bad line feed.
    row(SYNC_A); row(SYNC_B); row(8'h00); row(8'h01); row(8'h5A); row(8'h5A);
    row(TRAIL_CR);
    row_exp(8'h00, KIND_TRAIL_ERR, 8'h00, 16'd0, 8'h5A, 16'd1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    for (int i = 0; i < dir_rows.size(); i++)
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    run_phase(17'd7, 160, 1'b1, 1'b0);
    run_phase(17'd0, 100, 1'b0, 1'b0);
    run_phase(17'd6, 60, 1'b0, 1'b0);
    run_phase(17'h1FFFF, 200, 1'b0, 1'b1);
    run_phase(17'd65542, 150, 1'b0, 1'b0);
    run_phase(17'd65541, 100, 1'b0, 1'b0);
    run_phase(17'($urandom_range(400, 7)), 200, 1'b1, 1'b0);
    run_phase(17'($urandom_range(400, 7)), 200, 1'b0, 1'b1);
    run_phase(17'($urandom_range(17'h1FFFF)), 150, 1'b0, 1'b0);
    run_phase(MAX_LEN_RESET, 100, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
